@@ design/rhrb_pkg.sv @@
// Shared types and constants for the replay history ring buffer.
// No dependencies; used by rhrb_ctrl and replay_history_ring_buffer.
`timescale 1ns / 1ps

package rhrb_pkg;

    localparam int DEF_BUFFER_DEPTH   = 1024;
    localparam int DEF_SNAPSHOT_WIDTH = 64;

    // Fixed port field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 64;
    localparam int MODE_W = 3;
    localparam int POS_W  = 10;
    localparam int FILL_W = 11;
    localparam int STEP_W = 4;

    // Stream word widths: data, mode, replay pos, write pos, fill, padded to bytes
    localparam int RES_BITS = DATA_W + MODE_W + POS_W + POS_W + FILL_W;
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_REWIND_STEPS = 1'b0;
    localparam logic [STEP_W-1:0] REWIND_STEPS_RESET = 4'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 3'd0,
        MODE_RECORD = 3'd1,
        MODE_REPLAY = 3'd2,
        MODE_STOP   = 3'd3,
        MODE_REWIND = 3'd4
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP    = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_REWIND  = 3'd2,
        CMD_REPLAY  = 3'd3,
        CMD_RECORD  = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REWIND,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic              replay_valid;
        logic [MODE_W-1:0] mode_now;
        logic [POS_W-1:0]  replay_position;
        logic [POS_W-1:0]  write_position;
        logic [FILL_W-1:0] fill_level;
    } t_result;

endpackage

@@ design/rhrb_store.sv @@
// History memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rhrb_store #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/rhrb_ctrl.sv @@
// Pointer, count and mode sequencer; drives the history memory ports.
// Depends on rhrb_pkg.
`timescale 1ns / 1ps

module rhrb_ctrl #(
    parameter int DEPTH  = 1024,
    parameter int SNAP_W = 64,
    parameter int PW     = $clog2(DEPTH),
    parameter int CW     = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input side
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rhrb_pkg::CMD_W-1:0]   i_cmd,
    input  logic [rhrb_pkg::DATA_W-1:0]  i_sample,
    input  logic [rhrb_pkg::STEP_W-1:0]  i_rewind_steps,
    // result side
    input  logic                         i_out_free,
    output logic                         o_done,
    output rhrb_pkg::t_result            o_result,
    output logic [rhrb_pkg::DATA_W-1:0]  o_data,
    // memory
    output logic                         o_wr_en,
    output logic [PW-1:0]                o_wr_addr,
    output logic [SNAP_W-1:0]            o_wr_data,
    output logic                         o_rd_en,
    output logic [PW-1:0]                o_rd_addr,
    input  logic [SNAP_W-1:0]            i_rd_data
);

    localparam logic [rhrb_pkg::STEP_W-1:0] STEP_ONE = 1;

    rhrb_pkg::t_state r_state, n_state;
    rhrb_pkg::t_mode  r_mode, n_mode;
    rhrb_pkg::t_cmd   r_cmd, n_cmd;
    logic [SNAP_W-1:0]               r_sample, n_sample;
    logic [PW-1:0]                   r_wr, n_wr;
    logic [PW-1:0]                   r_rp, n_rp;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_pending, n_pending;
    logic                            r_shown, n_shown;
    logic [rhrb_pkg::STEP_W-1:0]     r_cnt, n_cnt;

    logic [PW-1:0]   wp_next;
    logic [PW-1:0]   rp_next;
    logic [PW-1:0]   newest;
    logic [PW-1:0]   rw_p;
    rhrb_pkg::t_mode rw_mode;
    rhrb_pkg::t_mode tmp_mode;
    logic            is_step_rewind;

    function automatic logic [PW-1:0] wrap_up(input logic [PW-1:0] p);
        wrap_up = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wp_next = wrap_up(r_wr);
    assign rp_next = wrap_up(r_rp);
    assign newest  = (r_wr == '0) ? PW'(DEPTH - 1) : r_wr - 1'b1;

    // One backward move of the rewind walk
    always_comb begin
        rw_p    = r_rp;
        rw_mode = r_mode;
        if (r_rp == '0) begin
            if (r_count != CW'(DEPTH)) begin
                rw_mode = rhrb_pkg::MODE_STOP;
            end else begin
                rw_p = PW'(DEPTH - 1);
            end
        end else begin
            rw_p = r_rp - 1'b1;
        end
        if (rw_p == r_wr) begin
            rw_mode = rhrb_pkg::MODE_STOP;
            rw_p    = wrap_up(rw_p);
        end
    end

    assign is_step_rewind = (r_cmd == rhrb_pkg::CMD_STEP) &&
                            (r_mode == rhrb_pkg::MODE_REWIND) &&
                            (i_rewind_steps != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rhrb_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rhrb_pkg::ST_EXEC;
            end
            rhrb_pkg::ST_EXEC: begin
                n_state = is_step_rewind ? rhrb_pkg::ST_REWIND : rhrb_pkg::ST_RESULT;
            end
            rhrb_pkg::ST_REWIND: begin
                if (r_cnt == STEP_ONE) n_state = rhrb_pkg::ST_RESULT;
            end
            rhrb_pkg::ST_RESULT: begin
                if (i_out_free) n_state = rhrb_pkg::ST_IDLE;
            end
            default: n_state = rhrb_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_mode    = r_mode;
        n_cmd     = r_cmd;
        n_sample  = r_sample;
        n_wr      = r_wr;
        n_rp      = r_rp;
        n_count   = r_count;
        n_pending = r_pending;
        n_shown   = r_shown;
        n_cnt     = r_cnt;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wr;
        o_wr_data = r_sample;
        o_rd_en   = 1'b0;
        o_rd_addr = r_rp;
        tmp_mode  = r_mode;

        unique case (r_state)
            rhrb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = rhrb_pkg::t_cmd'(i_cmd);
                    n_sample = i_sample[SNAP_W-1:0];
                end
            end

            rhrb_pkg::ST_EXEC: begin
                n_shown = 1'b0;
                priority case (r_cmd)
                    rhrb_pkg::CMD_STEP: begin
                        priority case (r_mode)
                            rhrb_pkg::MODE_START, rhrb_pkg::MODE_RECORD: begin
                                o_wr_en = 1'b1;
                                if (r_count != CW'(DEPTH)) n_count = r_count + 1'b1;
                                n_wr = wp_next;
                                n_rp = wp_next;
                                tmp_mode = r_mode;
                                if (r_pending) begin
                                    tmp_mode  = rhrb_pkg::MODE_STOP;
                                    n_pending = 1'b0;
                                end
                                if (tmp_mode == rhrb_pkg::MODE_START) begin
                                    tmp_mode = rhrb_pkg::MODE_STOP;
                                end
                                n_mode = tmp_mode;
                            end
                            rhrb_pkg::MODE_REPLAY: begin
                                if (r_rp == r_wr) begin
                                    // caught up: pending single step survives
                                    n_mode = rhrb_pkg::MODE_RECORD;
                                end else begin
                                    n_rp      = rp_next;
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = rp_next;
                                    n_shown   = 1'b1;
                                    if (rp_next == newest) n_mode = rhrb_pkg::MODE_RECORD;
                                    if (r_pending) begin
                                        n_mode    = rhrb_pkg::MODE_STOP;
                                        n_pending = 1'b0;
                                    end
                                end
                            end
                            rhrb_pkg::MODE_REWIND: begin
                                n_shown = 1'b1;
                                n_cnt   = i_rewind_steps;
                                if (i_rewind_steps == '0) begin
                                    o_rd_en = 1'b1;
                                    if (r_pending) begin
                                        n_mode    = rhrb_pkg::MODE_STOP;
                                        n_pending = 1'b0;
                                    end
                                end
                            end
                            default: begin
                                if (r_pending) begin
                                    n_mode    = rhrb_pkg::MODE_STOP;
                                    n_pending = 1'b0;
                                end
                            end
                        endcase
                    end
                    rhrb_pkg::CMD_STOP: begin
                        if (r_mode == rhrb_pkg::MODE_STOP) begin
                            n_pending = 1'b1;
                            n_mode = (r_rp == r_wr) ? rhrb_pkg::MODE_RECORD
                                                    : rhrb_pkg::MODE_REPLAY;
                        end else begin
                            n_mode = rhrb_pkg::MODE_STOP;
                        end
                    end
                    rhrb_pkg::CMD_REWIND: n_mode = rhrb_pkg::MODE_REWIND;
                    rhrb_pkg::CMD_REPLAY: n_mode = rhrb_pkg::MODE_REPLAY;
                    rhrb_pkg::CMD_RECORD: n_mode = rhrb_pkg::MODE_RECORD;
                    rhrb_pkg::CMD_CLEAR: begin
                        n_wr      = '0;
                        n_rp      = '0;
                        n_count   = '0;
                        n_mode    = rhrb_pkg::MODE_START;
                        n_pending = 1'b0;
                    end
                    default: ;
                endcase
            end

            rhrb_pkg::ST_REWIND: begin
                n_rp  = rw_p;
                n_cnt = r_cnt - 1'b1;
                tmp_mode = rw_mode;
                if (r_cnt == STEP_ONE) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = rw_p;
                    if (r_pending) begin
                        tmp_mode  = rhrb_pkg::MODE_STOP;
                        n_pending = 1'b0;
                    end
                end
                n_mode = tmp_mode;
            end

            rhrb_pkg::ST_RESULT: ;

            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rhrb_pkg::ST_IDLE;
            r_mode    <= rhrb_pkg::MODE_START;
            r_wr      <= '0;
            r_rp      <= '0;
            r_count   <= '0;
            r_pending <= 1'b0;
            r_shown   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_wr      <= n_wr;
            r_rp      <= n_rp;
            r_count   <= n_count;
            r_pending <= n_pending;
            r_shown   <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sample <= n_sample;
        r_cnt    <= n_cnt;
    end

    assign o_in_ready = (r_state == rhrb_pkg::ST_IDLE);
    assign o_done     = (r_state == rhrb_pkg::ST_RESULT);

    assign o_result.replay_valid    = r_shown;
    assign o_result.mode_now        = r_mode;
    assign o_result.replay_position = rhrb_pkg::POS_W'(r_rp);
    assign o_result.write_position  = rhrb_pkg::POS_W'(r_wr);
    assign o_result.fill_level      = rhrb_pkg::FILL_W'(r_count);

    // memory data is valid in RESULT, the cycle after the read was issued
    assign o_data = r_shown ? rhrb_pkg::DATA_W'(i_rd_data) : '0;

endmodule

@@ design/replay_history_ring_buffer.sv @@
// Replay history ring buffer top level: stream ports, APB register, result register.
// Depends on rhrb_pkg, rhrb_store and rhrb_ctrl.
`timescale 1ns / 1ps

// Records one snapshot word per step into a BUFFER_DEPTH-entry ring and plays
// it back forward (replay) or backward (rewind), returning exactly one result
// word per input word. Items are processed one at a time: each word goes
// through accept, execute (with at most one memory access) and result load,
// and a step in rewind mode with nonzero rewind_steps adds a rewind walk that
// moves the replay pointer back one entry per cycle before the memory read is
// issued. A finished result waits in the output register, so the next input
// word can be accepted and worked on while it is still unclaimed. The history
// memory has no reset; playing back an entry never written returns garbage.
// rewind_steps sits at byte address 0 of the APB port and resets to 4.

module replay_history_ring_buffer #(
    parameter int BUFFER_DEPTH   = rhrb_pkg::DEF_BUFFER_DEPTH,
    parameter int SNAPSHOT_WIDTH = rhrb_pkg::DEF_SNAPSHOT_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rhrb_pkg::DATA_W-1:0]        s_axis_tdata,  // [63:0] sample_word
    input  logic [rhrb_pkg::CMD_W-1:0]         s_axis_tuser,  // [2:0] cmd
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] replay_data, [66:64] mode_now, [76:67] replay_position,
    // [86:77] write_position, [97:87] fill_level, upper bits zero
    output logic [rhrb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tuser,  // [0] replay_valid
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rhrb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rhrb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rhrb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [rhrb_pkg::STEP_W-1:0] r_rewind_steps;
    logic                        reg_hit;

    logic                        r_out_valid;
    rhrb_pkg::t_result           r_out_res;
    logic [rhrb_pkg::DATA_W-1:0] r_out_data;

    logic                        out_free;
    logic                        done;
    rhrb_pkg::t_result           w_result;
    logic [rhrb_pkg::DATA_W-1:0] w_data;

    logic                        wr_en;
    logic [PW-1:0]               wr_addr;
    logic [SNAPSHOT_WIDTH-1:0]   wr_data;
    logic                        rd_en;
    logic [PW-1:0]               rd_addr;
    logic [SNAPSHOT_WIDTH-1:0]   rd_data;

    logic                        in_accept;

    // ---------------- configuration register ----------------
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == rhrb_pkg::REG_REWIND_STEPS);
    assign prdata  = reg_hit ? rhrb_pkg::APB_DATA_W'(r_rewind_steps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rewind_steps <= rhrb_pkg::REWIND_STEPS_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_rewind_steps <= pwdata[rhrb_pkg::STEP_W-1:0];
        end
    end

    // ---------------- core ----------------
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    rhrb_ctrl #(
        .DEPTH  (BUFFER_DEPTH),
        .SNAP_W (SNAPSHOT_WIDTH),
        .PW     (PW),
        .CW     (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_cmd          (s_axis_tuser),
        .i_sample       (s_axis_tdata),
        .i_rewind_steps (r_rewind_steps),
        .i_out_free     (out_free),
        .o_done         (done),
        .o_result       (w_result),
        .o_data         (w_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data)
    );

    rhrb_store #(
        .DEPTH  (BUFFER_DEPTH),
        .WIDTH  (SNAPSHOT_WIDTH),
        .ADDR_W (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_out_res  <= w_result;
            r_out_data <= w_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.replay_valid;
    assign m_axis_tdata  = rhrb_pkg::OUT_TDATA_W'({r_out_res.fill_level,
                                                    r_out_res.write_position,
                                                    r_out_res.replay_position,
                                                    r_out_res.mode_now,
                                                    r_out_data});

    // ---------------- assertions ----------------
    // one word in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input accepted while a word is in progress");

    // write pointer moves only in the execute cycle of an accepted word
    a_wp_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(w_result.write_position) |-> $past(in_accept, 2))
        else $error("write position changed without an accepted word");

    // playback never reports start mode
    a_shown_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.replay_valid) |->
            (r_out_res.mode_now != rhrb_pkg::MODE_START))
        else $error("played-back entry reported in start mode");

    // status-only results carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_res.replay_valid) |-> (r_out_data == '0))
        else $error("nonzero data without replay_valid");

endmodule
